>>> rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, codes and tables of the reflectance sorter controller.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int LEVEL_W  = 10;
	localparam int CLASS_W  = 2;
	localparam int KIND_W   = 2;
	localparam int DIR_W    = 2;
	localparam int STEPS_W  = 7;
	localparam int COUNT_W  = 16;
	localparam int FLIGHT_W = 5;
	localparam int NCLASS   = 4;
	localparam int CFG_IDX_W = 4;

	// operation codes
	localparam logic [1:0] OP_ENTRY  = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_EXIT   = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CLASS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HALT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

	// turn directions
	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

	localparam logic [STEPS_W-1:0] STEPS_ONE = 7'd50;
	localparam logic [STEPS_W-1:0] STEPS_TWO = 7'd100;

	localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 10'h3ff;
	localparam logic [COUNT_W-1:0]  COUNT_MAX  = 16'hffff;
	localparam logic [FLIGHT_W-1:0] FLIGHT_MAX = 5'd31;
	localparam logic [CLASS_W-1:0]  BIN_RESET  = 2'd3;

	// number of configuration registers
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 4'd8;

	// item handed from the decision stage to the tray stage
	typedef struct packed {
		logic                has_res;
		logic [KIND_W-1:0]   kind;
		logic [CLASS_W-1:0]  cls;
		logic                pop;
		logic [FLIGHT_W-1:0] flight;
	} rsc_tok_t;

	// position of each bin in clockwise order 3,0,2,1
	function automatic logic [1:0] bin_pos(input logic [CLASS_W-1:0] bin);
		logic [1:0] p;
		case (bin)
			2'd0: p = 2'd1;
			2'd1: p = 2'd3;
			2'd2: p = 2'd2;
			2'd3: p = 2'd0;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/rsc_class_queue.sv
// ----------------------------------------------------------------------------
// rsc_class_queue
// Class FIFO held in a synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module rsc_class_queue #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [rsc_pkg::CLASS_W-1:0]  push_data,
	input  logic                         pop,
	output logic [rsc_pkg::CLASS_W-1:0]  rd_data,
	output logic                         empty,
	output logic                         full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [rsc_pkg::CLASS_W-1:0] mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [FW-1:0] fill_q;
	logic [rsc_pkg::CLASS_W-1:0] rd_q;

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == FW'(DEPTH));
	assign rd_data = rd_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		if (pop) begin
			rd_q <= mem[head_q];
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + AW'(1);
			end
			if (pop) begin
				head_q <= (head_q == LAST) ? '0 : head_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

>>> rtl/rsc_classify.sv
// ----------------------------------------------------------------------------
// rsc_classify
// Decision stage: range registers, running minimum, classification, halt
// latch, in-flight count and queue push/pop requests.
// ----------------------------------------------------------------------------
module rsc_classify (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsc_pkg::LEVEL_W-1:0]     cfg_data,
	input  logic                            fire,
	input  logic [1:0]                      operation,
	input  logic [rsc_pkg::LEVEL_W-1:0]     sample,
	input  logic                            object_present,
	input  logic                            q_empty,
	input  logic                            q_full,
	input  logic                            adv,
	output logic                            q_push,
	output logic [rsc_pkg::CLASS_W-1:0]     q_push_data,
	output logic                            q_pop,
	output logic                            tok_valid_s1,
	output rsc_pkg::rsc_tok_t               tok_s1
);

	logic [rsc_pkg::LEVEL_W-1:0] lo_q [rsc_pkg::NCLASS];
	logic [rsc_pkg::LEVEL_W-1:0] hi_q [rsc_pkg::NCLASS];
	logic [rsc_pkg::LEVEL_W-1:0] min_q;
	logic [rsc_pkg::FLIGHT_W-1:0] flight_q;
	logic halted_q;

	logic [rsc_pkg::LEVEL_W-1:0] min_new;
	logic [rsc_pkg::LEVEL_W-1:0] min_d;
	logic [rsc_pkg::FLIGHT_W-1:0] flight_d;
	logic halted_d;
	logic hit;
	logic [rsc_pkg::CLASS_W-1:0] hit_cls;
	logic push_d;
	logic pop_d;
	rsc_pkg::rsc_tok_t tok_d;

	// configuration writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rsc_pkg::NCLASS; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index < rsc_pkg::CFG_COUNT)) begin
			if (cfg_index[0]) begin
				hi_q[cfg_index[2:1]] <= cfg_data;
			end else begin
				lo_q[cfg_index[2:1]] <= cfg_data;
			end
		end
	end

	// lowered minimum and first matching range
	always_comb begin
		min_new = (sample < min_q) ? sample : min_q;
		hit     = 1'b0;
		hit_cls = '0;
		for (int i = rsc_pkg::NCLASS - 1; i >= 0; i--) begin
			if ((min_new >= lo_q[i]) && (min_new < hi_q[i])) begin
				hit     = 1'b1;
				hit_cls = rsc_pkg::CLASS_W'(i);
			end
		end
	end

	// per-operation decision
	always_comb begin
		min_d    = min_q;
		flight_d = flight_q;
		halted_d = halted_q;
		push_d   = 1'b0;
		pop_d    = 1'b0;
		tok_d.has_res = 1'b0;
		tok_d.kind    = rsc_pkg::KIND_CLASS;
		tok_d.cls     = '0;
		tok_d.pop     = 1'b0;
		if (halted_q) begin
			tok_d.has_res = 1'b1;
			tok_d.kind    = rsc_pkg::KIND_HALT;
		end else begin
			case (operation)
				rsc_pkg::OP_ENTRY: begin
					min_d = rsc_pkg::LEVEL_MAX;
					if (flight_q != rsc_pkg::FLIGHT_MAX) begin
						flight_d = flight_q + rsc_pkg::FLIGHT_W'(1);
					end
				end
				rsc_pkg::OP_SAMPLE: begin
					min_d = min_new;
					if (!object_present) begin
						tok_d.has_res = 1'b1;
						if (!hit) begin
							halted_d   = 1'b1;
							tok_d.kind = rsc_pkg::KIND_HALT;
						end else begin
							push_d     = !q_full;
							tok_d.kind = rsc_pkg::KIND_CLASS;
							tok_d.cls  = hit_cls;
						end
					end
				end
				rsc_pkg::OP_EXIT: begin
					tok_d.has_res = 1'b1;
					if (q_empty) begin
						tok_d.kind = rsc_pkg::KIND_EMPTY;
					end else begin
						pop_d      = 1'b1;
						tok_d.kind = rsc_pkg::KIND_MOVE;
						tok_d.pop  = 1'b1;
						if (flight_q != '0) begin
							flight_d = flight_q - rsc_pkg::FLIGHT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
		tok_d.flight = flight_d;
	end

	assign q_push      = fire && push_d;
	assign q_pop       = fire && pop_d;
	assign q_push_data = hit_cls;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q        <= rsc_pkg::LEVEL_MAX;
			flight_q     <= '0;
			halted_q     <= 1'b0;
			tok_valid_s1 <= 1'b0;
		end else begin
			if (fire) begin
				min_q    <= min_d;
				flight_q <= flight_d;
				halted_q <= halted_d;
			end
			if (fire) begin
				tok_valid_s1 <= 1'b1;
			end else if (adv) begin
				tok_valid_s1 <= 1'b0;
			end
		end
	end

	// stage register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			tok_s1 <= tok_d;
		end
	end

endmodule

>>> rtl/rsc_tray.sv
// ----------------------------------------------------------------------------
// rsc_tray
// Tray stage: turn from the current bin, per-class counts and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module rsc_tray (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tok_valid_s1,
	input  rsc_pkg::rsc_tok_t            tok_s1,
	input  logic [rsc_pkg::CLASS_W-1:0]  rd_data,
	output logic                         adv,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,
	output logic [1:0]                   m_tuser
);

	logic [rsc_pkg::COUNT_W-1:0] counts_q [rsc_pkg::NCLASS];
	logic [rsc_pkg::CLASS_W-1:0] bin_q;
	logic out_valid_q;
	logic [31:0] data_q;
	logic [1:0]  kind_q;

	logic [rsc_pkg::CLASS_W-1:0] sel;
	logic [rsc_pkg::COUNT_W-1:0] cnt_cur;
	logic [rsc_pkg::COUNT_W-1:0] cnt_inc;
	logic [1:0] diff;
	logic [rsc_pkg::DIR_W-1:0]   dir;
	logic [rsc_pkg::STEPS_W-1:0] steps;
	logic [rsc_pkg::CLASS_W-1:0] o_cls;
	logic [rsc_pkg::COUNT_W-1:0] o_cnt;
	logic fire_s1;

	assign adv     = !out_valid_q || m_tready;
	assign fire_s1 = tok_valid_s1 && adv;

	// count lookup and tray turn
	always_comb begin
		sel     = tok_s1.pop ? rd_data : tok_s1.cls;
		cnt_cur = counts_q[sel];
		cnt_inc = (cnt_cur == rsc_pkg::COUNT_MAX) ? cnt_cur
			: cnt_cur + rsc_pkg::COUNT_W'(1);
		diff = rsc_pkg::bin_pos(sel) - rsc_pkg::bin_pos(bin_q);
		case (diff)
			2'd0: begin dir = rsc_pkg::DIR_NONE; steps = '0; end
			2'd1: begin dir = rsc_pkg::DIR_CW;   steps = rsc_pkg::STEPS_ONE; end
			2'd2: begin dir = rsc_pkg::DIR_CW;   steps = rsc_pkg::STEPS_TWO; end
			default: begin dir = rsc_pkg::DIR_CCW; steps = rsc_pkg::STEPS_ONE; end
		endcase
		o_cls = '0;
		o_cnt = '0;
		case (tok_s1.kind)
			rsc_pkg::KIND_CLASS: begin
				o_cls = sel;
				o_cnt = cnt_cur;
				dir   = rsc_pkg::DIR_NONE;
				steps = '0;
			end
			rsc_pkg::KIND_MOVE: begin
				o_cls = sel;
				o_cnt = cnt_inc;
			end
			default: begin
				dir   = rsc_pkg::DIR_NONE;
				steps = '0;
			end
		endcase
	end

	// bin and count state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rsc_pkg::NCLASS; i++) begin
				counts_q[i] <= '0;
			end
			bin_q       <= rsc_pkg::BIN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1 && tok_s1.pop) begin
				counts_q[sel] <= cnt_inc;
				bin_q         <= sel;
			end
			if (adv) begin
				out_valid_q <= tok_valid_s1 && tok_s1.has_res;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (fire_s1 && tok_s1.has_res) begin
			kind_q <= tok_s1.kind;
			data_q <= {tok_s1.flight, o_cnt, steps, dir, o_cls};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;

endmodule

>>> rtl/reflectance_sorter_controller.sv
// Each result passes the decision stage register and then the output register.
// Throughput: one item per cycle unless the output stalls; the class memory is
// read with the pop and the count and bin update in the next stage keep pace.
// Reset: arst_n clears pointers, counts, control registers and flags at once;
// the class memory is not cleared and no entry is read before it is written.
// ----------------------------------------------------------------------------
// reflectance_sorter_controller
// Conveyor sorter: classifies objects by minimum reflectance, queues the
// classes and reports tray turns at the exit.
// ----------------------------------------------------------------------------
module reflectance_sorter_controller #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample[9:0], object_present[10], zero fill
	input  logic [1:0]  s_tuser,   // operation[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // object_class[1:0], turn_direction[3:2],
	                               // turn_steps[10:4], class_count[26:11],
	                               // in_flight[31:27]
	output logic [1:0]  m_tuser    // result_kind[1:0]
);

	logic fire;
	logic adv;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;
	logic [rsc_pkg::CLASS_W-1:0] q_push_data;
	logic [rsc_pkg::CLASS_W-1:0] q_rd_data;
	logic tok_valid_s1;
	rsc_pkg::rsc_tok_t tok_s1;

	// input transaction handshake
	assign cfg_ready = 1'b1;
	assign s_tready  = !tok_valid_s1 || adv;
	assign fire      = s_tvalid && s_tready;

	rsc_classify u_classify (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fire           (fire),
		.operation      (s_tuser),
		.sample         (s_tdata[9:0]),
		.object_present (s_tdata[10]),
		.q_empty        (q_empty),
		.q_full         (q_full),
		.adv            (adv),
		.q_push         (q_push),
		.q_push_data    (q_push_data),
		.q_pop          (q_pop),
		.tok_valid_s1   (tok_valid_s1),
		.tok_s1         (tok_s1)
	);

	rsc_class_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.rd_data   (q_rd_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	rsc_tray u_tray (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid_s1 (tok_valid_s1),
		.tok_s1       (tok_s1),
		.rd_data      (q_rd_data),
		.adv          (adv),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule

>>> rtl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks of the sorter controller, bound to the top level.
// ----------------------------------------------------------------------------
module rsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic seen_fault_q;
	logic out_fire;

	assign out_fire = m_tvalid && m_tready;

	// remembers that a fault result has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_fault_q <= 1'b0;
		end else if (out_fire && (m_tuser == rsc_pkg::KIND_HALT)) begin
			seen_fault_q <= 1'b1;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// once faulted, every later result is a fault
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && seen_fault_q |-> m_tuser == rsc_pkg::KIND_HALT)
		else $error("result after fault is not a fault");

	// a tray move has a consistent turn
	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == rsc_pkg::KIND_MOVE) |->
		((m_tdata[3:2] == rsc_pkg::DIR_NONE) && (m_tdata[10:4] == 7'd0)) ||
		((m_tdata[3:2] == rsc_pkg::DIR_CW) &&
			((m_tdata[10:4] == rsc_pkg::STEPS_ONE) || (m_tdata[10:4] == rsc_pkg::STEPS_TWO))) ||
		((m_tdata[3:2] == rsc_pkg::DIR_CCW) && (m_tdata[10:4] == rsc_pkg::STEPS_ONE)))
		else $error("inconsistent tray turn");

	// fault and empty-queue results carry no class, turn or count
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == rsc_pkg::KIND_HALT) || (m_tuser == rsc_pkg::KIND_EMPTY)) |->
		m_tdata[26:0] == 27'd0)
		else $error("nonzero fields in fault or empty result");

endmodule

bind reflectance_sorter_controller rsc_checker u_rsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
